// ===== hw/rtl/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants and types for the pedal plausibility throttle block.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    // Pedal position in hundredths of a percent
    localparam int POS_BITS = 14;
    localparam int CNT_BITS = $clog2(POS_BITS + 1);
    localparam logic [POS_BITS-1:0] FULL_SCALE      = POS_BITS'(10000);
    localparam logic [POS_BITS-1:0] BRAKE_ARM_LEVEL = POS_BITS'(8000);
    localparam logic [POS_BITS-1:0] MISMATCH_LIMIT  = POS_BITS'(1000);

    localparam int BUZZ_BITS    = 8;
    localparam int CFG_IDX_BITS = 3;

    // Register reset values
    localparam int APPS0_MIN_RST = 310;
    localparam int APPS0_MAX_RST = 2792;
    localparam int APPS1_MIN_RST = 372;
    localparam int APPS1_MAX_RST = 3350;
    localparam int BRAKE_MIN_RST = 310;
    localparam int BRAKE_MAX_RST = 2792;
    localparam logic [BUZZ_BITS-1:0] BUZZER_TICKS_RST = BUZZ_BITS'(30);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_APPS0_MIN    = 3'd0,
        REG_APPS0_MAX    = 3'd1,
        REG_APPS1_MIN    = 3'd2,
        REG_APPS1_MAX    = 3'd3,
        REG_BRAKE_MIN    = 3'd4,
        REG_BRAKE_MAX    = 3'd5,
        REG_BUZZER_TICKS = 3'd6
    } ppt_cfg_idx_t;

    // Status returned by the serial divider
    typedef struct packed {
        logic                done;
        logic                bad;
        logic [POS_BITS-1:0] pos;
    } ppt_div_res_t;

endpackage

// ===== hw/rtl/ppt_div.sv =====
// ----------------------------------------------------------------------------
// ppt_div
// Converts one sensor count to a pedal position, (s - lo) * 10000 / (hi - lo),
// with a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div
    import ppt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] lo,
    input  logic [SAMPLE_BITS-1:0] hi,
    output ppt_div_res_t           res
);

    localparam int PW = SAMPLE_BITS + POS_BITS;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_RUN
    } div_state_t;

    div_state_t             state_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [SAMPLE_BITS-1:0] num_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [POS_BITS-1:0]    dvd_reg;
    logic                   bad_reg;
    logic                   done_reg;

    logic [PW-1:0]          prod;
    logic [SAMPLE_BITS+1:0] trial;
    logic                   qbit;
    logic [SAMPLE_BITS-1:0] rem_next;

    assign prod = PW'(num_reg) * PW'(FULL_SCALE);

    // Trial subtract of the divisor from the partial remainder
    assign trial = {1'b0, rem_reg, dvd_reg[POS_BITS-1]} - {2'b00, den_reg};
    assign qbit  = ~trial[SAMPLE_BITS+1];

    always_comb
    begin
        if (qbit)
        begin
            rem_next = trial[SAMPLE_BITS-1:0];
        end
        else
        begin
            rem_next = {rem_reg[SAMPLE_BITS-2:0], dvd_reg[POS_BITS-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            done_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        num_reg <= sample - lo;
                        den_reg <= hi - lo;
                        bad_reg <= (hi <= lo);
                        priority if (hi <= lo || sample <= lo)
                        begin
                            dvd_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else if (sample >= hi)
                        begin
                            dvd_reg  <= FULL_SCALE;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= D_MUL;
                        end
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                D_MUL:
                begin
                    // Quotient stays below full scale, so the top bits are below the divisor
                    rem_reg   <= prod[PW-1:POS_BITS];
                    dvd_reg   <= prod[POS_BITS-1:0];
                    cnt_reg   <= CNT_BITS'(POS_BITS);
                    done_reg  <= 1'b0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[POS_BITS-2:0], qbit};
                    cnt_reg  <= cnt_reg - 1'b1;
                    done_reg <= (cnt_reg == CNT_BITS'(1));
                    if (cnt_reg == CNT_BITS'(1))
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.bad  = bad_reg;
    assign res.pos  = dvd_reg;

endmodule

// ===== hw/rtl/pedal_plausibility_throttle.sv =====
// ----------------------------------------------------------------------------
// pedal_plausibility_throttle
// Accelerator pedal plausibility check with ready-to-drive arming.
// ----------------------------------------------------------------------------
// Each accepted word is one sample tick and yields exactly one result word.
// Every pedal position goes through a single shared bit-serial divider. A full
// conversion runs operand setup, one multiply by full scale, 14 quotient steps
// and the result; a count at or outside a limit, or a limit pair with max not
// above min, finishes at operand setup. A tick before arming converts the brake
// only; an armed tick converts both throttle sensors; the tick that arms
// converts all three. A finished result waits on out_stall before it is
// written to the output register.
// A finished result sits in the output register while the next word is taken.
// Configuration writes are taken at once through cfg_we, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module pedal_plausibility_throttle
    import ppt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]  cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_BITS-1:0]  apps0_sample,
    input  logic [SAMPLE_BITS-1:0]  apps1_sample,
    input  logic [SAMPLE_BITS-1:0]  brake_sample,
    input  logic                    start_pressed,
    input  logic                    system_active,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    ready_to_drive,
    output logic [POS_BITS-1:0]     throttle_out,
    output logic                    implausible,
    output logic                    buzzer_on
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        SEN_BRAKE,
        SEN_APPS0,
        SEN_APPS1
    } sensor_t;

    // Configuration registers
    logic [SAMPLE_BITS-1:0] apps0_min_reg, apps0_max_reg;
    logic [SAMPLE_BITS-1:0] apps1_min_reg, apps1_max_reg;
    logic [SAMPLE_BITS-1:0] brake_min_reg, brake_max_reg;
    logic [BUZZ_BITS-1:0]   buzzer_ticks_reg;

    // Control and block state
    state_t                 state_reg;
    sensor_t                sensor_reg;
    logic                   armed_reg;
    logic                   fault_reg;
    logic [POS_BITS-1:0]    throttle_held_reg;
    logic [BUZZ_BITS-1:0]   buzzer_count_reg;
    logic                   arm_tick_reg;
    logic                   out_valid_reg;

    // Latched word
    logic [SAMPLE_BITS-1:0] a0_reg, a1_reg, br_reg;
    logic                   start_reg, active_reg;
    logic [POS_BITS-1:0]    p0_reg;
    logic                   bad0_reg;

    // Output registers
    logic                   ready_reg;
    logic [POS_BITS-1:0]    throttle_reg;
    logic                   implausible_reg;
    logic                   buzzer_on_reg;

    // Divider hookup
    logic                   div_start;
    logic [SAMPLE_BITS-1:0] div_sample, div_lo, div_hi;
    ppt_div_res_t           div_res;

    logic                   accept;
    logic                   arm_now;
    logic [POS_BITS-1:0]    diff;
    logic [POS_BITS:0]      sum;
    logic                   range_bad;
    logic                   fault_now;
    logic [BUZZ_BITS-1:0]   buzzer_next;
    logic                   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == S_LAUNCH);

    always_comb
    begin
        unique case (sensor_reg)
            SEN_APPS0:
            begin
                div_sample = a0_reg;
                div_lo     = apps0_min_reg;
                div_hi     = apps0_max_reg;
            end
            SEN_APPS1:
            begin
                div_sample = a1_reg;
                div_lo     = apps1_min_reg;
                div_hi     = apps1_max_reg;
            end
            default:
            begin
                div_sample = br_reg;
                div_lo     = brake_min_reg;
                div_hi     = brake_max_reg;
            end
        endcase
    end

    ppt_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .sample (div_sample),
        .lo     (div_lo),
        .hi     (div_hi),
        .res    (div_res)
    );

    assign arm_now = !div_res.bad && (div_res.pos >= BRAKE_ARM_LEVEL) &&
                     start_reg && active_reg;

    // Second throttle position arrives on div_res.pos
    assign diff = (p0_reg > div_res.pos) ? (p0_reg - div_res.pos) : (div_res.pos - p0_reg);
    assign sum  = {1'b0, p0_reg} + {1'b0, div_res.pos};

    assign range_bad = (a0_reg < apps0_min_reg) || (a0_reg > apps0_max_reg) ||
                       (a1_reg < apps1_min_reg) || (a1_reg > apps1_max_reg);
    assign fault_now = bad0_reg || div_res.bad || range_bad || (diff > MISMATCH_LIMIT);

    // Decrement first; an arming load overrides it
    always_comb
    begin
        priority if (arm_tick_reg)
        begin
            buzzer_next = buzzer_ticks_reg;
        end
        else if (buzzer_count_reg != '0)
        begin
            buzzer_next = buzzer_count_reg - 1'b1;
        end
        else
        begin
            buzzer_next = buzzer_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apps0_min_reg    <= SAMPLE_BITS'(APPS0_MIN_RST);
            apps0_max_reg    <= SAMPLE_BITS'(APPS0_MAX_RST);
            apps1_min_reg    <= SAMPLE_BITS'(APPS1_MIN_RST);
            apps1_max_reg    <= SAMPLE_BITS'(APPS1_MAX_RST);
            brake_min_reg    <= SAMPLE_BITS'(BRAKE_MIN_RST);
            brake_max_reg    <= SAMPLE_BITS'(BRAKE_MAX_RST);
            buzzer_ticks_reg <= BUZZER_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_APPS0_MIN:    apps0_min_reg    <= cfg_data;
                REG_APPS0_MAX:    apps0_max_reg    <= cfg_data;
                REG_APPS1_MIN:    apps1_min_reg    <= cfg_data;
                REG_APPS1_MAX:    apps1_max_reg    <= cfg_data;
                REG_BRAKE_MIN:    brake_min_reg    <= cfg_data;
                REG_BRAKE_MAX:    brake_max_reg    <= cfg_data;
                REG_BUZZER_TICKS: buzzer_ticks_reg <= cfg_data[BUZZ_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sensor_reg        <= SEN_BRAKE;
            armed_reg         <= 1'b0;
            fault_reg         <= 1'b1;
            throttle_held_reg <= '0;
            buzzer_count_reg  <= '0;
            arm_tick_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            a0_reg            <= '0;
            a1_reg            <= '0;
            br_reg            <= '0;
            start_reg         <= 1'b0;
            active_reg        <= 1'b0;
            p0_reg            <= '0;
            bad0_reg          <= 1'b0;
            ready_reg         <= 1'b0;
            throttle_reg      <= '0;
            implausible_reg   <= 1'b1;
            buzzer_on_reg     <= 1'b0;
        end
        else
        begin
            // Drop the taken result; a new one from S_FIN replaces it below
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        a0_reg       <= apps0_sample;
                        a1_reg       <= apps1_sample;
                        br_reg       <= brake_sample;
                        start_reg    <= start_pressed;
                        active_reg   <= system_active;
                        arm_tick_reg <= 1'b0;
                        sensor_reg   <= armed_reg ? SEN_APPS0 : SEN_BRAKE;
                        state_reg    <= S_LAUNCH;
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_res.done)
                    begin
                        unique case (sensor_reg)
                            SEN_APPS0:
                            begin
                                p0_reg     <= div_res.pos;
                                bad0_reg   <= div_res.bad;
                                sensor_reg <= SEN_APPS1;
                                state_reg  <= S_LAUNCH;
                            end
                            SEN_APPS1:
                            begin
                                fault_reg         <= fault_now;
                                throttle_held_reg <= fault_now ? '0 : sum[POS_BITS:1];
                                state_reg         <= S_FIN;
                            end
                            default:
                            begin
                                if (arm_now)
                                begin
                                    armed_reg    <= 1'b1;
                                    arm_tick_reg <= 1'b1;
                                    sensor_reg   <= SEN_APPS0;
                                    state_reg    <= S_LAUNCH;
                                end
                                else
                                begin
                                    state_reg <= S_FIN;
                                end
                            end
                        endcase
                    end
                end
                S_FIN:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        buzzer_count_reg <= buzzer_next;
                        ready_reg        <= armed_reg;
                        throttle_reg     <= throttle_held_reg;
                        implausible_reg  <= fault_reg;
                        buzzer_on_reg    <= (buzzer_next != '0);
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign ready_to_drive = ready_reg;
    assign throttle_out   = throttle_reg;
    assign implausible    = implausible_reg;
    assign buzzer_on      = buzzer_on_reg;

    a_armed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |=> armed_reg)
        else $error("armed state dropped without reset");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_WAIT))
        else $error("divider result outside the wait state");

    a_fault_zero_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> (throttle_held_reg == '0))
        else $error("nonzero throttle held while implausible");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && sensor_reg == SEN_APPS1 && div_res.done && !fault_now)
            |=> (throttle_held_reg <= FULL_SCALE))
        else $error("throttle above full scale");

    a_unarmed_implausible: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> fault_reg)
        else $error("plausible result before arming");

endmodule
